// ===== hdl/blw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package blw_pkg;

  // Default grid capacity
  localparam int MAX_POINTS_DEF = 4096;

  // Field widths
  localparam int SAMPLE_W = 24;
  localparam int INDEX_W  = 12;
  localparam int DIFF_W   = 25;
  localparam int STEP_W   = 32;

  // Configuration register widths
  localparam int GRID_W    = 13;
  localparam int COURANT_W = 20;
  localparam int MARGIN_W  = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 25;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_POINTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COURANT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_MARGIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_MAX    = 2'd3;

  // Configuration reset values
  localparam logic [GRID_W-1:0]    GRID_RST     = 13'd4096;
  localparam logic [COURANT_W-1:0] COURANT_RST  = 20'd52418;
  localparam logic [MARGIN_W-1:0]  MARGIN_RST   = 10'd10;
  localparam logic [DIFF_W-1:0]    INIT_MAX_RST = 25'd2097;

  // Smallest usable grid
  localparam int N_MIN = 3;

  // Shared multiplier operand and product widths
  localparam int MUL_A_W = 28;
  localparam int MUL_B_W = 26;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Datapath operation codes
  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_MC   = 3'd1;  // u * courant
  localparam logic [2:0] OP_RC   = 3'd2;  // round to c
  localparam logic [2:0] OP_MT1  = 3'd3;  // c * d1
  localparam logic [2:0] OP_MC2  = 3'd4;  // round t1, c * c
  localparam logic [2:0] OP_RC2  = 3'd5;  // round to c^2
  localparam logic [2:0] OP_MT2  = 3'd6;  // c^2 * d2

  // Output register source select
  localparam logic [1:0] SEL_MAIN  = 2'd0;
  localparam logic [1:0] SEL_WRAP  = 2'd1;
  localparam logic [1:0] SEL_FINAL = 2'd2;

  typedef struct packed {
    logic       accept;
    logic [2:0] op;
    logic       load;
    logic [1:0] sel;
  } blw_cmd_t;

  typedef struct packed {
    logic has_result;
    logic last;
    logic slot_free;
  } blw_status_t;

endpackage

`default_nettype wire

// ===== hdl/blw_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module blw_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_stall,
  input  blw_pkg::blw_status_t status,
  output blw_pkg::blw_cmd_t    cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MC   = 4'd1;
  localparam logic [3:0] S_RC   = 4'd2;
  localparam logic [3:0] S_MT1  = 4'd3;
  localparam logic [3:0] S_MC2  = 4'd4;
  localparam logic [3:0] S_RC2  = 4'd5;
  localparam logic [3:0] S_MT2  = 4'd6;
  localparam logic [3:0] S_FIN  = 4'd7;
  localparam logic [3:0] S_WRAP = 4'd8;
  localparam logic [3:0] S_LAST = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  // Take samples only between updates
  assign sample_stall = (state != S_IDLE);

  // Decode commands and next state
  always_comb begin
    state_next = state;
    cmd.accept = 1'b0;
    cmd.op     = blw_pkg::OP_NONE;
    cmd.load   = 1'b0;
    cmd.sel    = blw_pkg::SEL_MAIN;
    unique case (state)
      S_IDLE: begin
        cmd.accept = sample_valid;
        if (sample_valid && status.has_result) state_next = S_MC;
      end
      S_MC: begin
        cmd.op     = blw_pkg::OP_MC;
        state_next = S_RC;
      end
      S_RC: begin
        cmd.op     = blw_pkg::OP_RC;
        state_next = S_MT1;
      end
      S_MT1: begin
        cmd.op     = blw_pkg::OP_MT1;
        state_next = S_MC2;
      end
      S_MC2: begin
        cmd.op     = blw_pkg::OP_MC2;
        state_next = S_RC2;
      end
      S_RC2: begin
        cmd.op     = blw_pkg::OP_RC2;
        state_next = S_MT2;
      end
      S_MT2: begin
        cmd.op     = blw_pkg::OP_MT2;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (status.slot_free) begin
          cmd.load   = 1'b1;
          cmd.sel    = blw_pkg::SEL_MAIN;
          state_next = status.last ? S_WRAP : S_IDLE;
        end
      end
      S_WRAP: begin
        if (status.slot_free) begin
          cmd.load   = 1'b1;
          cmd.sel    = blw_pkg::SEL_WRAP;
          state_next = S_LAST;
        end
      end
      S_LAST: begin
        if (status.slot_free) begin
          cmd.load   = 1'b1;
          cmd.sel    = blw_pkg::SEL_FINAL;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/blw_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module blw_datapath #(
  parameter int MAX_POINTS = blw_pkg::MAX_POINTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic signed [blw_pkg::SAMPLE_W-1:0]  sample_value,
  input  logic                                 cfg_valid,
  input  logic [blw_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [blw_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 result_stall,
  input  blw_pkg::blw_cmd_t                    cmd,
  output blw_pkg::blw_status_t                 status,
  output logic                                 result_valid,
  output logic [blw_pkg::INDEX_W-1:0]          point_index,
  output logic signed [blw_pkg::SAMPLE_W-1:0]  new_value,
  output logic                                 sweep_done,
  output logic [blw_pkg::DIFF_W-1:0]           step_max_diff,
  output logic [blw_pkg::DIFF_W-1:0]           global_max_diff,
  output logic [blw_pkg::STEP_W-1:0]           shock_step
);

  localparam int CW  = $clog2(MAX_POINTS);
  localparam int NW  = $clog2(MAX_POINTS + 1);
  localparam int WW  = ((NW > blw_pkg::GRID_W) ? NW : blw_pkg::GRID_W) + 1;
  localparam int SW  = blw_pkg::SAMPLE_W;
  localparam int DW  = blw_pkg::DIFF_W;
  localparam int IW  = blw_pkg::INDEX_W;
  localparam int PW  = blw_pkg::PROD_W;
  localparam int RW  = 34;
  localparam logic signed [RW-1:0] SAT_HI = RW'(64'sd8388607);
  localparam logic signed [RW-1:0] SAT_LO = -RW'(64'sd8388608);
  localparam logic signed [PW:0]   HALF20 = (PW + 1)'(64'sd524288);
  localparam logic signed [PW:0]   HALF21 = (PW + 1)'(64'sd1048576);

  // Configuration registers
  logic [blw_pkg::GRID_W-1:0]    grid_points;
  logic [blw_pkg::COURANT_W-1:0] courant_ratio;
  logic [blw_pkg::MARGIN_W-1:0]  edge_margin;

  // Sweep state
  logic signed [SW-1:0] win0;
  logic signed [SW-1:0] win1;
  logic signed [SW-1:0] first_result;
  logic [CW-1:0]        sample_count;
  logic [DW-1:0]        sweep_max;
  logic [DW-1:0]        overall_max;
  logic [31:0]          latched_shock_step;
  logic [31:0]          sweep_number;

  // Per-update operands
  logic signed [SW-1:0] u_reg;
  logic signed [24:0]   d1_reg;
  logic signed [25:0]   d2_reg;
  logic [IW-1:0]        j_idx;
  logic [IW-1:0]        i_idx;
  logic                 last;
  logic                 first_pt;
  logic [DW-1:0]        smax_reg;

  // Arithmetic registers
  logic signed [PW-1:0]  prod;
  logic signed [SW-1:0]  c_reg;
  logic signed [27:0]    t1_reg;
  logic signed [27:0]    c2_reg;
  logic signed [SW-1:0]  v_reg;

  // Index and window arithmetic at accept time
  logic [WW-1:0]        gp_ext;
  logic [WW-1:0]        n_eff;
  logic [WW-1:0]        i_ext;
  logic [WW-1:0]        j_ext;
  logic [WW-1:0]        m_ext;
  logic                 is_last;
  logic                 in_margin;
  logic signed [24:0]   d1_w;
  logic signed [25:0]   d2_w;
  logic [DW-1:0]        ad_w;
  logic [DW-1:0]        max_w;

  assign gp_ext = WW'(grid_points);
  assign n_eff  = (gp_ext < WW'(blw_pkg::N_MIN)) ? WW'(blw_pkg::N_MIN) :
                  (gp_ext > WW'(MAX_POINTS)) ? WW'(MAX_POINTS) : gp_ext;
  assign i_ext  = WW'(sample_count);
  assign j_ext  = i_ext - WW'(1);
  assign m_ext  = WW'(edge_margin);
  assign is_last   = (i_ext + WW'(1)) >= n_eff;
  assign in_margin = (j_ext >= m_ext) && ((j_ext + m_ext) <= (n_eff - WW'(1)));

  assign d1_w  = 25'(sample_value) - 25'(win0);
  assign d2_w  = 26'(sample_value) - 26'(win1) - 26'(win1) + 26'(win0);
  assign ad_w  = d1_w[24] ? DW'(-d1_w) : DW'(d1_w);
  assign max_w = (in_margin && (ad_w > sweep_max)) ? ad_w : sweep_max;

  assign status.has_result = (sample_count >= CW'(2));
  assign status.last       = last;
  assign status.slot_free  = !result_valid || !result_stall;

  // Shared multiplier operand select
  logic signed [blw_pkg::MUL_A_W-1:0] mul_a;
  logic signed [blw_pkg::MUL_B_W-1:0] mul_b;
  logic signed [PW-1:0]               prod_next;

  always_comb begin
    case (cmd.op)
      blw_pkg::OP_MC: begin
        mul_a = blw_pkg::MUL_A_W'(u_reg);
        mul_b = $signed(blw_pkg::MUL_B_W'(courant_ratio));
      end
      blw_pkg::OP_MT1: begin
        mul_a = blw_pkg::MUL_A_W'(c_reg);
        mul_b = blw_pkg::MUL_B_W'(d1_reg);
      end
      blw_pkg::OP_MC2: begin
        mul_a = blw_pkg::MUL_A_W'(c_reg);
        mul_b = blw_pkg::MUL_B_W'(c_reg);
      end
      blw_pkg::OP_MT2: begin
        mul_a = c2_reg;
        mul_b = d2_reg;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_next = mul_a * mul_b;

  // Round half up by arithmetic shift
  logic signed [PW:0] sum20;
  logic signed [PW:0] sum21;
  logic signed [31:0] t2_w;
  logic signed [RW-1:0] r_w;
  logic signed [SW-1:0] v_w;

  assign sum20 = (PW + 1)'(prod) + HALF20;
  assign sum21 = (PW + 1)'(prod) + HALF21;
  assign t2_w  = sum21[52:21];
  assign r_w   = RW'(u_reg) - RW'(t1_reg) + RW'(t2_w);
  assign v_w   = (r_w > SAT_HI) ? SW'(SAT_HI) :
                 (r_w < SAT_LO) ? SW'(SAT_LO) : r_w[SW-1:0];

  // Configuration and sweep state
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_points        <= blw_pkg::GRID_RST;
      courant_ratio      <= blw_pkg::COURANT_RST;
      edge_margin        <= blw_pkg::MARGIN_RST;
      overall_max        <= blw_pkg::INIT_MAX_RST;
      win0               <= '0;
      win1               <= '0;
      sample_count       <= '0;
      sweep_max          <= '0;
      latched_shock_step <= '0;
      sweep_number       <= '0;
      first_result       <= '0;
      last               <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          blw_pkg::REG_GRID_POINTS: grid_points   <= cfg_data[blw_pkg::GRID_W-1:0];
          blw_pkg::REG_COURANT:     courant_ratio <= cfg_data[blw_pkg::COURANT_W-1:0];
          blw_pkg::REG_EDGE_MARGIN: edge_margin   <= cfg_data[blw_pkg::MARGIN_W-1:0];
          blw_pkg::REG_INIT_MAX:    overall_max   <= cfg_data[DW-1:0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        if (status.has_result && is_last) begin
          // Close the sweep: global update, clear window
          last <= 1'b1;
          if (max_w > overall_max) begin
            overall_max        <= max_w;
            latched_shock_step <= sweep_number;
          end
          sweep_max    <= '0;
          sweep_number <= sweep_number + 32'd1;
          sample_count <= '0;
          win0         <= '0;
          win1         <= '0;
        end else begin
          last <= 1'b0;
          if (status.has_result) sweep_max <= max_w;
          win0         <= win1;
          win1         <= sample_value;
          sample_count <= sample_count + CW'(1);
        end
      end
      if (cmd.load && (cmd.sel == blw_pkg::SEL_MAIN) && first_pt) begin
        first_result <= v_w;
      end
    end
  end

  // Capture operands and step the arithmetic
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      u_reg    <= win1;
      d1_reg   <= d1_w;
      d2_reg   <= d2_w;
      j_idx    <= j_ext[IW-1:0];
      i_idx    <= i_ext[IW-1:0];
      first_pt <= (sample_count == CW'(2));
      smax_reg <= max_w;
    end
    case (cmd.op)
      blw_pkg::OP_MC:  prod <= prod_next;
      blw_pkg::OP_RC:  c_reg <= sum20[43:20];
      blw_pkg::OP_MT1: prod <= prod_next;
      blw_pkg::OP_MC2: begin
        t1_reg <= sum21[48:21];
        prod   <= prod_next;
      end
      blw_pkg::OP_RC2: c2_reg <= sum20[47:20];
      blw_pkg::OP_MT2: prod <= prod_next;
      default: ;
    endcase
    if (cmd.load && (cmd.sel == blw_pkg::SEL_MAIN)) v_reg <= v_w;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      global_max_diff <= overall_max;
      shock_step      <= latched_shock_step;
      unique case (cmd.sel)
        blw_pkg::SEL_MAIN: begin
          point_index   <= j_idx;
          new_value     <= v_w;
          sweep_done    <= 1'b0;
          step_max_diff <= '0;
        end
        blw_pkg::SEL_WRAP: begin
          point_index   <= '0;
          new_value     <= v_reg;
          sweep_done    <= 1'b0;
          step_max_diff <= '0;
        end
        default: begin
          point_index   <= i_idx;
          new_value     <= first_result;
          sweep_done    <= 1'b1;
          step_max_diff <= smax_reg;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/burgers_lax_wendroff_stencil_unit.sv =====
// Lax-Wendroff step of inviscid Burgers on a periodic grid, signed Q4.20.
// Grid samples enter in index order; the first two of each sweep are taken
// without a stall and give no result. Every later sample steps the controller
// through the MC, RC, MT1, MC2, RC2 and MT2 states and its result is loaded
// into the output register from FIN before the next sample is taken: the four
// dependent products c, c*d1, c^2 and c^2*d2 pass one after another through a
// single 28x26 multiplier, with rounding steps between them. The sample that
// ends a sweep (count reaches n-1, n = grid_points clamped to 3..MAX_POINTS)
// gives three results, updated point n-2, then point 0 and point n-1 from the
// WRAP and LAST states, each loaded when the output is not stalled, before the
// next sample is taken. A stalled output holds FIN, WRAP and LAST until the
// output register frees. The output register lets the next sample in while a
// result waits. Configuration writes are always ready and are meant for idle
// periods; writing initial_max_diff also reloads the running global maximum.
`timescale 1ns / 1ps
`default_nettype none

module burgers_lax_wendroff_stencil_unit #(
  parameter int MAX_POINTS = blw_pkg::MAX_POINTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 sample_valid,
  output logic                                 sample_stall,
  input  logic signed [blw_pkg::SAMPLE_W-1:0]  sample_value,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [blw_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [blw_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic [blw_pkg::INDEX_W-1:0]          point_index,
  output logic signed [blw_pkg::SAMPLE_W-1:0]  new_value,
  output logic                                 sweep_done,
  output logic [blw_pkg::DIFF_W-1:0]           step_max_diff,
  output logic [blw_pkg::DIFF_W-1:0]           global_max_diff,
  output logic [blw_pkg::STEP_W-1:0]           shock_step
);

  blw_pkg::blw_cmd_t    cmd;
  blw_pkg::blw_status_t status;

  assign cfg_ready = 1'b1;

  blw_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .status       (status),
    .cmd          (cmd)
  );

  blw_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .sample_value    (sample_value),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .result_stall    (result_stall),
    .cmd             (cmd),
    .status          (status),
    .result_valid    (result_valid),
    .point_index     (point_index),
    .new_value       (new_value),
    .sweep_done      (sweep_done),
    .step_max_diff   (step_max_diff),
    .global_max_diff (global_max_diff),
    .shock_step      (shock_step)
  );

endmodule

`default_nettype wire

// ===== hdl/blw_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module blw_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 sample_valid,
  input logic                                 sample_stall,
  input logic                                 result_valid,
  input logic                                 result_stall,
  input logic [blw_pkg::INDEX_W-1:0]          point_index,
  input logic signed [blw_pkg::SAMPLE_W-1:0]  new_value,
  input logic                                 sweep_done,
  input logic [blw_pkg::DIFF_W-1:0]           step_max_diff
);

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result_valid after reset");

  // A held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(point_index) && $stable(new_value) && $stable(sweep_done))
    else $error("stalled result changed");

  // Sweep maximum only travels with the closing result
  a_smax_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !sweep_done |-> step_max_diff == '0)
    else $error("step_max_diff set without sweep_done");

  // A rising result_valid never directly follows a sample transaction
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> !$past(sample_valid && !sample_stall))
    else $error("result appeared one cycle after a sample transaction");

endmodule

bind burgers_lax_wendroff_stencil_unit blw_checker u_blw_checker (.*);

`default_nettype wire
